>>> rtl/tdf_pkg.sv
// Shared types and constants of the trial division factorizer.
package tdf_pkg;

  localparam int unsigned MAX_RESULTS = 30;
  localparam int unsigned CNT_W       = 5;

  typedef enum logic {
    SEL_DIVISOR,
    SEL_NUMBER
  } put_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     step;
    logic     put;
    put_sel_e put_sel;
    logic     put_last;
  } cmd_t;

  typedef struct packed {
    logic below_two;
    logic sq_gt_num;
    logic sq_next_gt_num;
    logic div_done;
    logic rem_zero;
    logic d_eq_num;
    logic cap_reached;
    logic out_free;
  } status_t;

endpackage

>>> rtl/tdf_if.sv
// Valid/ready channel interfaces for the factorizer input and result streams.
interface tdf_in_if #(
  parameter int unsigned WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface tdf_out_if #(
  parameter int unsigned WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] factor_value;
  logic                    last;

  modport source (output valid, output factor_value, output last, input ready);
  modport sink   (input valid, input factor_value, input last, output ready);
endinterface

>>> rtl/trial_division_factorizer_unit.sv
// Top level of the trial division factorizer.
//
// in_i carries one signed number per transaction; out_o returns its prime
// factors in ascending order with multiplicity, one per transaction, with
// last set on the final one. Numbers below two come back unchanged as one
// result with last set.
// Items are worked one at a time: in_i is ready only while the sequencer
// is idle. A pass-through result goes through S_TEST and S_PUT_N to the output register.
// Each odd trial candidate (and two) takes one division in the radix-2
// divider, and each divisor found to be a factor is emitted from S_PUT_D.
// Search stops once the candidate squared exceeds the cofactor.
// A single output register holds each result; while out_o is stalled the
// sequencer waits before writing the next one. Reset returns the sequencer
// to idle and empties the output register.
module trial_division_factorizer_unit
  import tdf_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdf_in_if.sink      in_i,
  tdf_out_if.source   out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdf_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .number_i       (in_i.number),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .factor_value_o (out_o.factor_value),
    .last_o         (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

>>> rtl/tdf_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module tdf_divider #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DW    = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [DW-1:0]    rem_o
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [WIDTH-1:0] q_q;
  logic [DW-1:0]    r_q;
  logic [DW-1:0]    dv_q;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  assign trial = {r_q, q_q[WIDTH-1]};
  assign fits  = trial >= {1'b0, dv_q};
  assign diff  = trial - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[WIDTH-2:0], fits};
      r_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (r_q < dv_q))
    else $error("divider remainder not below divisor");

endmodule

>>> rtl/tdf_ctrl.sv
// Sequencer for trial division: load, divide, step candidate, emit factors.
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PUT_D = 3'd3;
  localparam logic [2:0] S_PUT_N = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.below_two || status_i.sq_gt_num) begin
          state_d = S_PUT_N;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            state_d = S_PUT_D;
          end else begin
            cmd_o.step = 1'b1;
            if (status_i.sq_next_gt_num) begin
              state_d = S_PUT_N;
            end else begin
              cmd_o.div_start = 1'b1;
            end
          end
        end
      end
      S_PUT_D: begin
        if (status_i.out_free) begin
          cmd_o.put      = 1'b1;
          cmd_o.put_sel  = SEL_DIVISOR;
          cmd_o.put_last = status_i.d_eq_num || status_i.cap_reached;
          state_d        = cmd_o.put_last ? S_IDLE : S_TEST;
        end
      end
      S_PUT_N: begin
        if (status_i.out_free) begin
          cmd_o.put      = 1'b1;
          cmd_o.put_sel  = SEL_NUMBER;
          cmd_o.put_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tdf_datapath.sv
// Cofactor, candidate and square registers, divider and result register.
module tdf_datapath
  import tdf_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic signed [WIDTH-1:0] number_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [WIDTH-1:0] factor_value_o,
  output logic                    last_o
);

  localparam int unsigned DW  = WIDTH / 2 + 1;
  localparam int unsigned SQW = WIDTH + 1;

  logic [WIDTH-1:0] num_q;
  logic [DW-1:0]    d_q;
  logic [DW-1:0]    d_nx;
  logic [SQW-1:0]   sq_q;
  logic [SQW-1:0]   sq_nx;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] dext;
  logic             out_valid_q;
  logic [WIDTH-1:0] factor_q;
  logic             last_q;
  logic             out_free;
  logic             div_busy;
  logic             div_done;
  logic [WIDTH-1:0] quot;
  logic [DW-1:0]    rem;

  assign dext = {{(WIDTH - DW){1'b0}}, d_q};

  // skip even candidates once two is done
  always_comb begin
    if (d_q == DW'(2)) begin
      d_nx  = DW'(3);
      sq_nx = SQW'(9);
    end else begin
      d_nx  = d_q + DW'(2);
      sq_nx = sq_q + SQW'({d_q, 2'b00}) + SQW'(4);
    end
  end

  tdf_divider #(
    .WIDTH (WIDTH),
    .DW    (DW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (cmd_i.step ? d_nx : d_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= $unsigned(number_i);
      d_q   <= DW'(2);
      sq_q  <= SQW'(4);
    end else begin
      if (cmd_i.step) begin
        d_q  <= d_nx;
        sq_q <= sq_nx;
      end
      if (cmd_i.put && cmd_i.put_sel == SEL_DIVISOR) begin
        num_q <= quot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.put) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      factor_q <= (cmd_i.put_sel == SEL_DIVISOR) ? dext : num_q;
      last_q   <= cmd_i.put_last;
    end
  end

  always_comb begin
    status_o.below_two      = num_q[WIDTH-1] || (num_q < WIDTH'(2));
    status_o.sq_gt_num      = sq_q > {1'b0, num_q};
    status_o.sq_next_gt_num = sq_nx > {1'b0, num_q};
    status_o.div_done       = div_done;
    status_o.rem_zero       = rem == '0;
    status_o.d_eq_num       = dext == num_q;
    status_o.cap_reached    = cnt_q == CNT_W'(MAX_RESULTS - 1);
    status_o.out_free       = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign factor_value_o = $signed(factor_q);
  assign last_o         = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put && cmd_i.put_sel == SEL_DIVISOR |-> rem == '0)
    else $error("divisor emitted without exact division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> out_free)
    else $error("result register overwritten while occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("division started while divider busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");

endmodule

>>> tb/sv/testbench.sv
// Testbench of trial_division_factorizer_unit: drives numbers, checks every factor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WIDTH        = 32;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam longint      CYCLE_LIMIT  = 20_000_000;

  class factor_scoreboard;

    typedef struct packed {
      logic signed [WIDTH-1:0] factor_value;
      logic                    last;
    } factor_t;

    factor_t     expected_factors[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return expected_factors.size();
    endfunction

    function void push_factor(logic signed [WIDTH-1:0] value, logic last);
      factor_t item;
      item.factor_value = value;
      item.last         = last;
      expected_factors  = {expected_factors, item};
    endfunction

    // Factor an accepted number by trial division and queue its factors.
    function void add_number(logic signed [WIDTH-1:0] number);
      longint unsigned cofactor;
      longint unsigned divisor;
      int unsigned     count;
      if (number < 2) begin
        push_factor(number, 1'b1);
        return;
      end
      cofactor = longint'(number);
      divisor  = 2;
      count    = 0;
      while (divisor * divisor <= cofactor) begin
        while (cofactor >= 2 && cofactor % divisor == 0) begin
          if (count < tdf_pkg::MAX_RESULTS) begin
            push_factor(divisor[WIDTH-1:0], 1'b0);
            count++;
          end
          cofactor = cofactor / divisor;
        end
        divisor++;
      end
      if (cofactor >= 2 && count < tdf_pkg::MAX_RESULTS) begin
        push_factor(cofactor[WIDTH-1:0], 1'b0);
        count++;
      end
      expected_factors[expected_factors.size() - 1].last = 1'b1;
    endfunction

    function void check_factor(logic signed [WIDTH-1:0] factor_value, logic last);
      factor_t want;
      if (expected_factors.size() == 0) begin
        $error("unexpected transaction: factor_value %0d last %0b", factor_value, last);
        fail_count++;
        return;
      end
      want = expected_factors.pop_front();
      if (factor_value !== want.factor_value) begin
        $error("factor_value: expected %0d, actual %0d", want.factor_value, factor_value);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        fail_count++;
      end
    endfunction

  endclass

  logic   clk_i  = 1'b0;
  logic   rst_ni = 1'b0;
  longint cycle_count = 0;
  int     stall_mode  = 0;
  int     mode_cycles = 0;

  factor_scoreboard sb = new();

  tdf_in_if  #(.WIDTH(WIDTH)) in_if ();
  tdf_out_if #(.WIDTH(WIDTH)) out_if ();

  trial_division_factorizer_unit #(
    .WIDTH(WIDTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL trial_division_factorizer_unit");
      $finish;
    end
  end

  // Check each result transaction and stall on a pattern of changing modes.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_factor(out_if.factor_value, out_if.last);
    end
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(20, 200);
    end else begin
      mode_cycles--;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      default: out_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_number(input logic signed [WIDTH-1:0] value);
    in_if.valid  <= 1'b1;
    in_if.number <= value;
    do @(posedge clk_i); while (!in_if.ready);
    sb.add_number(value);
  endtask

  task automatic wait_all_factors();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [WIDTH-1:0] random_number();
    int unsigned     kind;
    longint unsigned value;
    longint unsigned bound;
    longint unsigned factor;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: return $urandom | 32'h8000_0000;
      2: return $urandom_range(0, 1);
      3, 4, 5, 6: begin
        // Build a smooth number below a random power of two.
        bound = (64'd1 << $urandom_range(1, 31)) - 1;
        value = 1;
        forever begin
          factor = 64'($urandom_range(2, 97));
          if (value * factor > bound) break;
          value = value * factor;
        end
        return value[WIDTH-1:0];
      end
      7, 8: return $urandom_range(2, 16383);
      default: return $urandom_range(2, 1 << 20);
    endcase
  endfunction

  int directed_numbers[$] = '{
    0, 1, -1, 32'h8000_0000, 32'h7fff_ffff, 2, 3, 4, 6, 8, 9, 25, 97,
    63001, 65537, 32'h4000_0000, 32'h6000_0000, 223092870, 2147483646,
    32'h5555_5555, -2
  };

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    in_if.valid  <= 1'b0;
    in_if.number <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_numbers[i]) send_number(directed_numbers[i]);
    in_if.valid <= 1'b0;
    wait_all_factors();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 8);
      for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
        send_number(random_number());
        sent++;
      end
      in_if.valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) wait_all_factors();
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end

    wait_all_factors();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS trial_division_factorizer_unit");
    end else begin
      $display("FAIL trial_division_factorizer_unit");
    end
    $finish;
  end

endmodule
